// ===== sv/dpls_pkg.sv =====
// Shared types, constants and helpers for the dash pattern line splitter.
// No dependencies.
`default_nettype none
package dpls_pkg;

  localparam int COORD_W = 32;
  localparam int MAG_W   = 33;
  localparam int EST_W   = 35;
  localparam int LEN_W   = 24;
  localparam int CNT_W   = 3;
  localparam int PADDR_W = 5;

  localparam logic [1:0] CMD_MOVE  = 2'd0;
  localparam logic [1:0] CMD_LINE  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  localparam logic [2:0] REG_DASH_COUNT = 3'd0;
  localparam logic [2:0] REG_DASH_LEN0  = 3'd1;
  localparam logic [2:0] REG_DASH_LEN5  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EST_FIRST,
    ST_FIRST,
    ST_EST_LOOP,
    ST_LOOP,
    ST_WAIT_X,
    ST_WAIT_Y,
    ST_STEP,
    ST_TAIL,
    ST_FINISH
  } state_t;

  // q - p as 33-bit two's complement
  function automatic logic [MAG_W-1:0] diff(input logic [COORD_W-1:0] q,
                                            input logic [COORD_W-1:0] p);
    diff = {q[COORD_W-1], q} - {p[COORD_W-1], p};
  endfunction

  function automatic logic [MAG_W-1:0] diff_mag(input logic [COORD_W-1:0] q,
                                                input logic [COORD_W-1:0] p);
    logic [MAG_W-1:0] d;
    d = diff(q, p);
    diff_mag = d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
  endfunction

  // max + 3/8 min
  function automatic logic [EST_W-1:0] est_len(input logic [COORD_W-1:0] x0,
                                               input logic [COORD_W-1:0] y0,
                                               input logic [COORD_W-1:0] x1,
                                               input logic [COORD_W-1:0] y1);
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] mn;
    logic [EST_W-1:0] mn3;
    ax = diff_mag(x1, x0);
    ay = diff_mag(y1, y0);
    mx = (ax > ay) ? ax : ay;
    mn = (ax > ay) ? ay : ax;
    mn3 = {2'b00, mn} + {1'b0, mn, 1'b0};
    est_len = {2'b00, mx} + (mn3 >> 3);
  endfunction

endpackage
`default_nettype wire

// ===== sv/dpls_muldiv.sv =====
// Shared iterative unit: q = (a * b) / den, shift-add multiply then restoring divide.
// Depends on dpls_pkg.
`default_nettype none
module dpls_muldiv (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [dpls_pkg::MAG_W-1:0]  a,
  input  wire logic [dpls_pkg::LEN_W-1:0]  b,
  input  wire logic [dpls_pkg::EST_W-1:0]  den,
  output logic                             busy,
  output logic                             done,
  output logic [dpls_pkg::MAG_W-1:0]       q
);
  import dpls_pkg::*;

  localparam int PW = LEN_W + MAG_W + 1;

  logic             phase;
  logic [5:0]       cnt;
  logic [MAG_W-1:0] a_r;
  logic [EST_W-1:0] den_r;
  logic [PW-1:0]    p;
  logic [EST_W:0]   r;

  logic [MAG_W+1:0] sum;
  logic [EST_W:0]   rsh;
  logic             ge;

  always_comb begin
    sum = {1'b0, p[PW-1:LEN_W]} + (p[0] ? {2'b00, a_r} : '0);
    rsh = {r[EST_W-1:0], p[PW-1]};
    ge  = rsh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      a_r   <= a;
      den_r <= den;
      p     <= {{(PW-LEN_W){1'b0}}, b};
      r     <= '0;
      cnt   <= '0;
      phase <= 1'b0;
      busy  <= 1'b1;
    end else if (busy) begin
      if (!phase) begin
        p <= {sum, p[LEN_W-1:1]};
        if (cnt == 6'(LEN_W - 1)) begin
          phase <= 1'b1;
          cnt   <= '0;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end else begin
        r   <= ge ? (rsh - {1'b0, den_r}) : rsh;
        p   <= {p[PW-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(PW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

  assign q = p[MAG_W-1:0];

endmodule
`default_nettype wire

// ===== sv/dpls_regs.sv =====
// APB register file: dash count and dash pattern lengths.
// Depends on dpls_pkg.
`default_nettype none
module dpls_regs #(
  parameter int MAX_DASH = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dpls_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output logic [dpls_pkg::CNT_W-1:0]         dash_count,
  output logic [dpls_pkg::LEN_W-1:0]         dash_len [MAX_DASH]
);
  import dpls_pkg::*;

  logic [2:0] ridx;
  logic [2:0] k;
  logic       wr;

  assign ridx   = paddr[4:2];
  assign k      = ridx - REG_DASH_LEN0;
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_count <= CNT_W'(1);
      for (int i = 0; i < MAX_DASH; i++) dash_len[i] <= LEN_W'(256);
    end else if (wr) begin
      if (ridx == REG_DASH_COUNT) begin
        dash_count <= pwdata[CNT_W-1:0];
      end else if (ridx >= REG_DASH_LEN0 && ridx <= REG_DASH_LEN5) begin
        for (int i = 0; i < MAX_DASH; i++)
          if (32'(k) == 32'(i)) dash_len[i] <= pwdata[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (ridx == REG_DASH_COUNT) begin
      prdata = {{(32-CNT_W){1'b0}}, dash_count};
    end else if (ridx >= REG_DASH_LEN0 && ridx <= REG_DASH_LEN5) begin
      for (int i = 0; i < MAX_DASH; i++)
        if (32'(k) == 32'(i)) prdata = {{(32-LEN_W){1'b0}}, dash_len[i]};
    end
  end

endmodule
`default_nettype wire

// ===== sv/dash_pattern_line_splitter_core.sv =====
// Top level of the dash pattern line splitter: sequencer, path state, output beat.
// Depends on dpls_pkg, dpls_regs, dpls_muldiv.
// Takes move/line/close beats and emits the visible pieces of each segment cut by a
// cyclic on/off dash pattern. One input is handled at a time; s_tready is high only
// while idle. A line or close that does not end inside the current entry runs the
// shared multiply/divide unit twice per split point, once per axis (24 multiply steps,
// then 58 divide steps); a split at the segment end skips the unit. A stall on
// m_tready holds the sequencer.
// Each piece is held one step so the final one can carry tlast and the overflow flag.
`default_nettype none
module dash_pattern_line_splitter_core #(
  parameter int MAX_DASH   = 6,
  parameter int MAX_PIECES = 64,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [63:0]   s_tdata,   // pt_x, pt_y
  input  wire logic [1:0]    s_tuser,   // cmd
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [127:0]       m_tdata,   // seg_x0, seg_y0, seg_x1, seg_y1
  output logic [0:0]         m_tuser,   // overflow
  output logic               m_tlast    // last_piece
);
  import dpls_pkg::*;

  localparam int IW = (MAX_DASH > 1) ? $clog2(MAX_DASH) : 1;
  localparam int CW = 5;
  localparam int NW = $clog2(MAX_PIECES + 1);

  logic [CNT_W-1:0] dash_count;
  logic [LEN_W-1:0] dash_len [MAX_DASH];

  dpls_regs #(.MAX_DASH(MAX_DASH)) u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .dash_count, .dash_len
  );

  state_t state, state_next;

  logic [COORD_W-1:0] cur_x, cur_y, sub_x, sub_y, px, py, tx, ty, sx, sy;
  logic [IW-1:0]      idx;
  logic [LEN_W-1:0]   rem;
  logic               in_gap;
  logic [EST_W-1:0]   len, e_reg;
  logic [NW-1:0]      n_out;
  logic               dropped;
  logic               d_neg;
  logic               pend_valid;
  logic [COORD_W-1:0] pend_x0, pend_y0, pend_x1, pend_y1;

  logic               md_start, md_busy, md_done;
  logic [MAG_W-1:0]   md_a, md_q;
  logic [COORD_W-1:0] split_val;

  logic               accept, out_free, cap_hit, emit_ok, len_gt, do_split, out_load;
  logic [CW-1:0]      ucnt, v, nxt_full;
  logic [IW-1:0]      nxt_idx;
  logic [LEN_W-1:0]   rem_tail;
  logic               near;

  dpls_muldiv u_md (
    .clk, .rst, .start(md_start), .a(md_a), .b(rem), .den(e_reg),
    .busy(md_busy), .done(md_done), .q(md_q)
  );

  always_comb begin
    if (dash_count == '0) ucnt = CW'(1);
    else if (32'(dash_count) > MAX_DASH) ucnt = CW'(MAX_DASH);
    else ucnt = CW'(dash_count);
  end

  // (idx + 1) mod count
  always_comb begin
    logic [2*CW-1:0] lo;
    v = {{(CW-IW){1'b0}}, idx} + CW'(1);
    nxt_full = '0;
    for (int k = 0; k <= MAX_DASH; k++) begin
      lo = (2*CW)'(k) * {{CW{1'b0}}, ucnt};
      if ({{CW{1'b0}}, v} >= lo && {{CW{1'b0}}, v} < lo + {{CW{1'b0}}, ucnt})
        nxt_full = v - lo[CW-1:0];
    end
    nxt_idx = nxt_full[IW-1:0];
  end

  always_comb begin
    logic [MAG_W:0]   off;
    logic [MAG_W:0]   sum;
    logic [COORD_W-1:0] base;
    accept   = s_tvalid && s_tready;
    out_free = !m_tvalid || m_tready;
    cap_hit  = !in_gap && (n_out >= NW'(MAX_PIECES));
    emit_ok  = in_gap || !pend_valid || out_free;
    len_gt   = len > {{(EST_W-LEN_W){1'b0}}, rem};
    do_split = (e_reg != '0) && ({{(EST_W-LEN_W){1'b0}}, rem} < e_reg);
    rem_tail = rem - len[LEN_W-1:0];
    near     = ({1'b0, rem_tail} < ((LEN_W+1)'(1) << FRAC_BITS)) &&
               ({len, 6'b0} >= ((EST_W+6)'(2) << FRAC_BITS));
    md_a     = (state == ST_LOOP) ? diff_mag(tx, px) : diff_mag(ty, py);
    base     = (state == ST_WAIT_X) ? px : py;
    off      = d_neg ? (~{1'b0, md_q} + (MAG_W+1)'(1)) : {1'b0, md_q};
    sum      = {base[COORD_W-1], base[COORD_W-1], base} + off;
    split_val = sum[COORD_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (accept && (s_tuser == CMD_LINE || s_tuser == CMD_CLOSE))
                      state_next = ST_EST_FIRST;
      ST_EST_FIRST: state_next = ST_FIRST;
      ST_FIRST:     state_next = (len < {{(EST_W-LEN_W){1'b0}}, rem}) ? ST_FINISH : ST_LOOP;
      ST_EST_LOOP:  state_next = ST_LOOP;
      ST_LOOP: begin
        priority if (!len_gt) state_next = ST_TAIL;
        else if (cap_hit)     state_next = ST_FINISH;
        else if (do_split)    state_next = ST_WAIT_X;
        else                  state_next = ST_STEP;
      end
      ST_WAIT_X:    if (md_done) state_next = ST_WAIT_Y;
      ST_WAIT_Y:    if (md_done) state_next = ST_STEP;
      ST_STEP:      if (emit_ok) state_next = ST_EST_LOOP;
      ST_TAIL:      if (cap_hit || emit_ok) state_next = ST_FINISH;
      ST_FINISH:    if (!pend_valid || out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    md_start = ((state == ST_LOOP) && len_gt && !cap_hit && do_split) ||
               ((state == ST_WAIT_X) && md_done);
    out_load = ((state == ST_STEP) && !in_gap && pend_valid && out_free) ||
               ((state == ST_TAIL) && !cap_hit && !in_gap && pend_valid && out_free) ||
               ((state == ST_FINISH) && pend_valid && out_free);
  end

  always_ff @(posedge clk) begin
    state <= state_next;
    unique case (state)
      ST_IDLE: if (accept) begin
        n_out   <= '0;
        dropped <= 1'b0;
        px      <= cur_x;
        py      <= cur_y;
        if (s_tuser == CMD_MOVE) begin
          cur_x  <= s_tdata[31:0];
          cur_y  <= s_tdata[63:32];
          sub_x  <= s_tdata[31:0];
          sub_y  <= s_tdata[63:32];
          idx    <= '0;
          rem    <= dash_len[0];
          in_gap <= 1'b0;
        end else if (s_tuser == CMD_LINE) begin
          tx <= s_tdata[31:0];
          ty <= s_tdata[63:32];
        end else begin
          tx <= sub_x;
          ty <= sub_y;
        end
      end
      ST_EST_FIRST: begin
        e_reg <= est_len(px, py, tx, ty);
        len   <= est_len(px, py, tx, ty);
      end
      ST_FIRST: if (len < {{(EST_W-LEN_W){1'b0}}, rem}) begin
        rem <= rem - len[LEN_W-1:0];
        if (!in_gap) begin
          pend_valid <= 1'b1;
          pend_x0 <= px; pend_y0 <= py; pend_x1 <= tx; pend_y1 <= ty;
          n_out <= NW'(1);
        end
      end
      ST_EST_LOOP: e_reg <= est_len(px, py, tx, ty);
      ST_LOOP: if (len_gt) begin
        if (cap_hit) dropped <= 1'b1;
        else if (do_split) d_neg <= diff(tx, px) >> (MAG_W-1) != '0;
        else begin
          sx <= tx;
          sy <= ty;
        end
      end
      ST_WAIT_X: if (md_done) begin
        sx    <= split_val;
        d_neg <= diff(ty, py) >> (MAG_W-1) != '0;
      end
      ST_WAIT_Y: if (md_done) sy <= split_val;
      ST_STEP: if (emit_ok) begin
        if (!in_gap) begin
          pend_valid <= 1'b1;
          pend_x0 <= px; pend_y0 <= py; pend_x1 <= sx; pend_y1 <= sy;
          n_out <= n_out + NW'(1);
        end
        len    <= len - {{(EST_W-LEN_W){1'b0}}, rem};
        idx    <= nxt_idx;
        rem    <= dash_len[nxt_idx];
        in_gap <= !in_gap;
        px     <= sx;
        py     <= sy;
      end
      ST_TAIL: begin
        if (cap_hit) dropped <= 1'b1;
        else if (emit_ok) begin
          if (!in_gap) begin
            pend_valid <= 1'b1;
            pend_x0 <= px; pend_y0 <= py; pend_x1 <= tx; pend_y1 <= ty;
            n_out <= n_out + NW'(1);
          end
          if (near) begin
            idx    <= nxt_idx;
            rem    <= dash_len[nxt_idx];
            in_gap <= !in_gap;
          end else begin
            rem <= rem_tail;
          end
        end
      end
      ST_FINISH: begin
        cur_x <= tx;
        cur_y <= ty;
        if (out_free) pend_valid <= 1'b0;
      end
      default: ;
    endcase

    if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {pend_y1, pend_x1, pend_y0, pend_x0};
      m_tlast  <= (state == ST_FINISH);
      m_tuser  <= (state == ST_FINISH) && dropped;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end

    if (rst) begin
      state      <= ST_IDLE;
      cur_x      <= '0;
      cur_y      <= '0;
      sub_x      <= '0;
      sub_y      <= '0;
      idx        <= '0;
      rem        <= '0;
      in_gap     <= 1'b0;
      n_out      <= '0;
      dropped    <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("piece still held while idle");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    n_out <= NW'(MAX_PIECES))
    else $error("piece count beyond cap");

  a_md_start: assert property (@(posedge clk) disable iff (rst)
    md_start |-> !md_busy)
    else $error("divider restarted while busy");

  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_WAIT_X || state == ST_WAIT_Y) && !md_done) |-> md_busy)
    else $error("waiting on idle divider");

endmodule
`default_nettype wire
